// ----- rtl/smu_pkg.sv -----
`default_nettype none
package smu_pkg;

    localparam int VALUE_BITS = 32;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef enum logic [1:0] {
        ACT_PUSH_A = 2'd0,
        ACT_PUSH_B = 2'd1,
        ACT_END_A  = 2'd2,
        ACT_END_B  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STATUS_DATA = 2'd0,
        STATUS_DONE = 2'd1,
        STATUS_DROP = 2'd2
    } status_t;

    typedef struct packed {
        action_t action;
        value_t  value;
    } in_item_t;

    typedef struct packed {
        value_t  merged_value;
        status_t status;
        logic    last;
    } out_item_t;

    // Classified request handed from the front queue to the merge engine.
    typedef struct packed {
        logic   is_push;
        logic   side_b;
        value_t value;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_FLUSH
    } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/smu_ram.sv -----
`default_nettype none
module smu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/smu_fifo.sv -----
`default_nettype none
module smu_fifo
    import smu_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       wr_en,
    input  wire value_t                     wr_data,
    input  wire logic                       rd_en,
    output value_t                          head,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          byp_reg, byp_next;
    value_t        byp_data_reg;
    logic [VALUE_BITS-1:0] ram_rdata;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_comb begin
        wr_ptr_next = wr_en ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + CW'(1);
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - CW'(1);
        end
        // RAM returns old data when the head slot is written this cycle
        byp_next = wr_en && (wr_ptr_reg == rd_ptr_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            byp_reg    <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            byp_reg    <= byp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byp_next) begin
            byp_data_reg <= wr_data;
        end
    end

    smu_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(wr_ptr_reg),
        .wdata(wr_data),
        .raddr(rd_ptr_next),
        .rdata(ram_rdata)
    );

    assign head  = byp_reg ? byp_data_reg : value_t'(ram_rdata);
    assign count = count_reg;

endmodule
`default_nettype wire

// ----- rtl/smu_front.sv -----
`default_nettype none
module smu_front
    import smu_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    cmd_t       cls;
    logic       push, pop;

    always_comb begin
        cls.value = s_data.value;
        unique case (s_data.action)
            ACT_PUSH_A: begin cls.is_push = 1'b1; cls.side_b = 1'b0; end
            ACT_PUSH_B: begin cls.is_push = 1'b1; cls.side_b = 1'b1; end
            ACT_END_A:  begin cls.is_push = 1'b0; cls.side_b = 1'b0; end
            ACT_END_B:  begin cls.is_push = 1'b0; cls.side_b = 1'b1; end
            default:    begin cls.is_push = 1'b0; cls.side_b = 1'b0; end
        endcase
    end

    assign s_ready   = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (!push && pop) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/smu_back.sv -----
`default_nettype none
module smu_back
    import smu_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_item_t m_data
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    back_state_t state_reg, state_next;
    logic        ended_a_reg, ended_a_next;
    logic        ended_b_reg, ended_b_next;
    value_t      prev_reg, prev_next;
    logic        prev_valid_reg, prev_valid_next;
    logic        pend_valid_reg, pend_valid_next;
    out_item_t   pend_reg, pend_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;

    logic          wr_a, wr_b, rd_a, rd_b;
    value_t        head_a, head_b;
    logic [CW-1:0] count_a, count_b;

    logic      have_a, have_b, full_a, full_b;
    logic      take_a, take_b, step;
    value_t    vsel;
    logic      out_free, stall;
    logic      emit_en;
    out_item_t emit_item;

    assign have_a   = (count_a != '0);
    assign have_b   = (count_b != '0);
    assign full_a   = (count_a == CW'(BUFFER_DEPTH));
    assign full_b   = (count_b == CW'(BUFFER_DEPTH));
    assign out_free = !m_valid_reg || m_ready;
    assign stall    = pend_valid_reg && !out_free;

    // Pick the next head to retire; equal heads retire together
    always_comb begin
        take_a = 1'b0;
        take_b = 1'b0;
        vsel   = head_a;
        priority if (have_a && have_b) begin
            if (head_a < head_b) begin
                take_a = 1'b1;
            end else if (head_b < head_a) begin
                take_b = 1'b1;
                vsel   = head_b;
            end else begin
                take_a = 1'b1;
                take_b = 1'b1;
            end
        end else if (have_a && ended_b_reg) begin
            take_a = 1'b1;
        end else if (have_b && ended_a_reg) begin
            take_b = 1'b1;
            vsel   = head_b;
        end else begin
            take_a = 1'b0;
        end
    end

    assign step = take_a || take_b;

    always_comb begin
        state_next      = state_reg;
        ended_a_next    = ended_a_reg;
        ended_b_next    = ended_b_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        cmd_ready       = 1'b0;
        wr_a            = 1'b0;
        wr_b            = 1'b0;
        rd_a            = 1'b0;
        rd_b            = 1'b0;
        emit_en         = 1'b0;
        emit_item       = '{merged_value: '0, status: STATUS_DATA, last: 1'b0};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    if (cmd.is_push) begin
                        if (cmd.side_b ? full_b : full_a) begin
                            // pend is empty here: hold the drop report directly
                            pend_valid_next = 1'b1;
                            pend_next = '{merged_value: cmd.value, status: STATUS_DROP,
                                          last: 1'b0};
                        end else begin
                            wr_a = !cmd.side_b;
                            wr_b = cmd.side_b;
                        end
                    end else if (cmd.side_b) begin
                        ended_b_next = 1'b1;
                    end else begin
                        ended_a_next = 1'b1;
                    end
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (!stall) begin
                    if (step) begin
                        rd_a = take_a;
                        rd_b = take_b;
                        // drop repeats of the last emitted value
                        if (!(prev_valid_reg && prev_reg == vsel)) begin
                            prev_next       = vsel;
                            prev_valid_next = 1'b1;
                            emit_en         = 1'b1;
                            emit_item.merged_value = vsel;
                        end
                    end else begin
                        if (ended_a_reg && ended_b_reg && !have_a && !have_b) begin
                            emit_en          = 1'b1;
                            emit_item.status = STATUS_DONE;
                            ended_a_next     = 1'b0;
                            ended_b_next     = 1'b0;
                            prev_next        = '0;
                            prev_valid_next  = 1'b0;
                        end
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_data_next      = pend_reg;
                    m_data_next.last = 1'b1;
                    pend_valid_next  = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A new result pushes the held one out, which is then known not to be final
        if (emit_en) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = pend_reg;
            end
            pend_valid_next = 1'b1;
            pend_next       = emit_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ended_a_reg    <= 1'b0;
            ended_b_reg    <= 1'b0;
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ended_a_reg    <= ended_a_next;
            ended_b_reg    <= ended_b_next;
            prev_reg       <= prev_next;
            prev_valid_reg <= prev_valid_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    smu_fifo #(
        .DEPTH(BUFFER_DEPTH)
    ) u_fifo_a (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (wr_a),
        .wr_data(cmd.value),
        .rd_en  (rd_a),
        .head   (head_a),
        .count  (count_a)
    );

    smu_fifo #(
        .DEPTH(BUFFER_DEPTH)
    ) u_fifo_b (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (wr_b),
        .wr_data(cmd.value),
        .rd_en  (rd_b),
        .head   (head_b),
        .count  (count_b)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ----- rtl/sorted_merge_union_unit.sv -----
// Sorted union of two ascending signed streams A and B, pushed interleaved on
// one request channel and tagged by action. A two-entry front queue takes and
// classifies requests; the merge engine behind it takes one request at a time.
// For each request it takes the request, retires heads in merge steps until
// none is left to retire, and then closes out the last result. Equal heads
// retire together in one step. The merge state machine makes one step per cycle
// while output back-pressure does not stall it. Each side is buffered in a
// BUFFER_DEPTH-entry RAM FIFO with no clearing pass after reset. Results carry
// last on the final one of each request; a full side reports the dropped value
// with the drop status, and completion of both sides yields a done result and
// restarts the union.
`default_nettype none
module sorted_merge_union_unit
    import smu_pkg::*;
#(
    parameter int BUFFER_DEPTH = 16
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    smu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd)
    );

    smu_back #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
`default_nettype wire
